>>> sv/text_glyph_framebuffer_writer_assert.svh
// Assertion macros for the text glyph frame-buffer writer.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef TEXT_GLYPH_FRAMEBUFFER_WRITER_ASSERT_SVH
`define TEXT_GLYPH_FRAMEBUFFER_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TGFW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TGFW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tgfw_pkg.sv
// Shared constants, codes and types for the text glyph frame-buffer writer.
// No dependencies.
package tgfw_pkg;

  localparam int GLYPH_COUNT  = 128;
  localparam int GLYPH_HEIGHT = 10;
  localparam int CODE_W       = $clog2(GLYPH_COUNT);
  localparam int LINE_W       = $clog2(GLYPH_HEIGHT);
  localparam int FONT_DEPTH   = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int FONT_ADDR_W  = $clog2(FONT_DEPTH);
  localparam int GLYPH_W      = 8;

  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 64;
  localparam int STRIDE_W   = 16;
  localparam int DEPTH_W    = 3;
  localparam int COL_W      = 8;
  localparam int ROW_W      = 8;
  localparam int WORD_W     = 2;
  localparam int BCNT_W     = 4;
  localparam int CMD_W      = 2;
  localparam int ROWLINE_W  = ROW_W + LINE_W;
  localparam int PROD_W     = ROWLINE_W + STRIDE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(GLYPH_HEIGHT - 1);

  // Commands
  localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CURSOR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LASTCOL = 2'd3;

  // Depth codes
  localparam logic [DEPTH_W-1:0] DEPTH_1BPP  = 3'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_2BPP  = 3'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_4BPP  = 3'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_8BPP  = 3'd3;
  localparam logic [DEPTH_W-1:0] DEPTH_16BPP = 3'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_32BPP = 3'd5;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 7'd10;

  // Pixel colors for the deep modes (inverted bit set / clear)
  localparam logic [15:0] PIX16_ON  = 16'h0021;
  localparam logic [15:0] PIX16_OFF = 16'h7FFF;
  localparam logic [31:0] PIX32_ON  = 32'h0000_0000;
  localparam logic [31:0] PIX32_OFF = 32'h00FF_FFFF;

  // Reset values
  localparam logic [ADDR_W-1:0]   RST_BASE    = '0;
  localparam logic [STRIDE_W-1:0] RST_STRIDE  = 16'd832;
  localparam logic [DEPTH_W-1:0]  RST_DEPTH   = DEPTH_8BPP;
  localparam logic [COL_W-1:0]    RST_LASTCOL = 8'd103;

  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [FONT_ADDR_W-1:0] addr;
    logic [GLYPH_W-1:0]     wdata;
  } font_req_t;

  typedef struct packed {
    logic [BCNT_W-1:0] byte_count;
    logic [WORD_W-1:0] last_word;
  } word_fmt_t;

endpackage

>>> sv/tgfw_font_store.sv
// Glyph memory: GLYPH_COUNT x GLYPH_HEIGHT rows of 8 bits, one write or read
// port per cycle, registered read data. Depends on tgfw_pkg.
module tgfw_font_store (
  input  logic                              clk,
  input  tgfw_pkg::font_req_t               req,
  output logic [tgfw_pkg::GLYPH_W-1:0]      rdata
);

  logic [tgfw_pkg::GLYPH_W-1:0] mem [tgfw_pkg::FONT_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

>>> sv/tgfw_pixel_expand.sv
// Expands one inverted glyph row to a big-endian frame-buffer word at the
// selected pixel depth. Depends on tgfw_pkg.
module tgfw_pixel_expand (
  input  logic [tgfw_pkg::GLYPH_W-1:0] inv_bits,
  input  logic [tgfw_pkg::DEPTH_W-1:0] depth,
  input  logic [tgfw_pkg::WORD_W-1:0]  word,
  output logic [tgfw_pkg::DATA_W-1:0]  data,
  output tgfw_pkg::word_fmt_t          fmt
);

  logic [2:0] pix16 [4];
  logic [2:0] pix32 [2];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      pix16[p] = {word[0], 2'(p)};
    end
    for (int p = 0; p < 2; p++) begin
      pix32[p] = {word, 1'(p)};
    end
  end

  always_comb begin
    data = '0;
    fmt.byte_count = tgfw_pkg::BCNT_W'(8);
    fmt.last_word = '0;
    unique case (depth)
      tgfw_pkg::DEPTH_1BPP: begin
        data[63:56] = inv_bits;
        fmt.byte_count = tgfw_pkg::BCNT_W'(1);
      end
      tgfw_pkg::DEPTH_2BPP: begin
        for (int i = 0; i < 8; i++) data[63-2*i -: 2] = {2{inv_bits[7-i]}};
        fmt.byte_count = tgfw_pkg::BCNT_W'(2);
      end
      tgfw_pkg::DEPTH_4BPP: begin
        for (int i = 0; i < 8; i++) data[63-4*i -: 4] = {4{inv_bits[7-i]}};
        fmt.byte_count = tgfw_pkg::BCNT_W'(4);
      end
      tgfw_pkg::DEPTH_8BPP: begin
        for (int i = 0; i < 8; i++) data[63-8*i -: 8] = {8{inv_bits[7-i]}};
      end
      tgfw_pkg::DEPTH_16BPP: begin
        for (int p = 0; p < 4; p++) begin
          data[63-16*p -: 16] = inv_bits[3'd7 - pix16[p]] ? tgfw_pkg::PIX16_ON
                                                           : tgfw_pkg::PIX16_OFF;
        end
        fmt.last_word = tgfw_pkg::WORD_W'(1);
      end
      tgfw_pkg::DEPTH_32BPP: begin
        for (int p = 0; p < 2; p++) begin
          data[63-32*p -: 32] = inv_bits[3'd7 - pix32[p]] ? tgfw_pkg::PIX32_ON
                                                           : tgfw_pkg::PIX32_OFF;
        end
        fmt.last_word = tgfw_pkg::WORD_W'(3);
      end
      default: begin
        data = '0;
      end
    endcase
  end

endmodule

>>> sv/text_glyph_framebuffer_writer.sv
// Text glyph frame-buffer writer, top level.
// Put-char: setup (row-offset multiply, base sum, first font read), then one
// frame-buffer write per cycle unless out_ready stalls: 10 writes at 1..8 bpp, 20 at
// 16, 40 at 32. Other commands are handled in idle. One font-store port serves both
// glyph loads and row reads. Reset (synchronous) clears the cursor and out_valid and
// loads the register defaults; the font store and output data are not cleared.
`include "text_glyph_framebuffer_writer_assert.svh"

module text_glyph_framebuffer_writer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tgfw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tgfw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tgfw_pkg::CMD_W-1:0]          cmd,
  input  logic [tgfw_pkg::CODE_W-1:0]         char_code,
  input  logic [tgfw_pkg::COL_W-1:0]          cursor_column,
  input  logic [tgfw_pkg::ROW_W-1:0]          cursor_row,
  input  logic [tgfw_pkg::LINE_W-1:0]         glyph_line,
  input  logic [tgfw_pkg::GLYPH_W-1:0]        font_bits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tgfw_pkg::ADDR_W-1:0]         address,
  output logic [tgfw_pkg::DATA_W-1:0]         data,
  output logic [tgfw_pkg::BCNT_W-1:0]         byte_count,
  output logic                                last
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;

  logic [tgfw_pkg::ADDR_W-1:0]      base_address;
  logic [tgfw_pkg::STRIDE_W-1:0]    line_stride;
  logic [tgfw_pkg::DEPTH_W-1:0]     depth_code;
  logic [tgfw_pkg::COL_W-1:0]       last_column;
  logic [tgfw_pkg::COL_W-1:0]       column_now;
  logic [tgfw_pkg::ROW_W-1:0]       row_now;

  logic [tgfw_pkg::LINE_W-1:0]      line_idx;
  logic [tgfw_pkg::WORD_W-1:0]      word_idx;
  logic [tgfw_pkg::FONT_ADDR_W-1:0] code_base;
  logic [tgfw_pkg::ROWLINE_W-1:0]   row_lines;
  logic [tgfw_pkg::PROD_W-1:0]      prod;
  logic [tgfw_pkg::ADDR_W-1:0]      row_base;
  logic [tgfw_pkg::ADDR_W-1:0]      addr_acc;

  logic                             in_fire;
  logic                             emit_fire;
  logic                             last_word;
  logic                             last_line;
  logic [tgfw_pkg::ROW_W-1:0]       row_inc;
  logic [tgfw_pkg::COL_W-1:0]       adv_col;
  logic [tgfw_pkg::ROW_W-1:0]       adv_row;
  logic [tgfw_pkg::FONT_ADDR_W-1:0] in_code_base;
  logic [tgfw_pkg::ADDR_W-1:0]      row_sum;
  logic [tgfw_pkg::ADDR_W-1:0]      next_row_base;

  tgfw_pkg::font_req_t              font_req;
  logic [tgfw_pkg::GLYPH_W-1:0]     font_rdata;
  logic [tgfw_pkg::DATA_W-1:0]      word_data;
  tgfw_pkg::word_fmt_t              fmt;

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign emit_fire = (state == ST_EMIT) && (!out_valid || out_ready);
  assign last_word = (word_idx == fmt.last_word);
  assign last_line = (line_idx == tgfw_pkg::LAST_LINE);

  // cursor advance with row saturation
  assign row_inc = (row_now == '1) ? row_now : row_now + 1'b1;
  assign adv_col = (column_now < last_column) ? column_now + 1'b1 : '0;
  assign adv_row = (column_now < last_column) ? row_now : row_inc;

  assign in_code_base = tgfw_pkg::FONT_ADDR_W'(char_code)
                      * tgfw_pkg::FONT_ADDR_W'(tgfw_pkg::GLYPH_HEIGHT);
  assign row_sum = base_address
                 + (tgfw_pkg::ADDR_W'(column_now) << depth_code)
                 + tgfw_pkg::ADDR_W'(prod);
  assign next_row_base = row_base + tgfw_pkg::ADDR_W'(line_stride);

  always_comb begin
    font_req.we    = in_fire && (cmd == tgfw_pkg::CMD_LOAD)
                  && (glyph_line < tgfw_pkg::LINE_W'(tgfw_pkg::GLYPH_HEIGHT));
    font_req.re    = (state == ST_SUM) || (emit_fire && last_word && !last_line);
    font_req.wdata = font_bits;
    if (font_req.we) begin
      font_req.addr = in_code_base + tgfw_pkg::FONT_ADDR_W'(glyph_line);
    end else if (state == ST_SUM) begin
      font_req.addr = code_base;
    end else begin
      font_req.addr = code_base + tgfw_pkg::FONT_ADDR_W'(line_idx)
                    + tgfw_pkg::FONT_ADDR_W'(1);
    end
  end

  tgfw_font_store u_font (
    .clk   (clk),
    .req   (font_req),
    .rdata (font_rdata)
  );

  tgfw_pixel_expand u_expand (
    .inv_bits (~font_rdata),
    .depth    (depth_code),
    .word     (word_idx),
    .data     (word_data),
    .fmt      (fmt)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      base_address <= tgfw_pkg::RST_BASE;
      line_stride  <= tgfw_pkg::RST_STRIDE;
      depth_code   <= tgfw_pkg::RST_DEPTH;
      last_column  <= tgfw_pkg::RST_LASTCOL;
      column_now   <= '0;
      row_now      <= '0;
      line_idx     <= '0;
      word_idx     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tgfw_pkg::CFG_BASE:    base_address <= cfg_data;
          tgfw_pkg::CFG_STRIDE:  line_stride  <= cfg_data[tgfw_pkg::STRIDE_W-1:0];
          tgfw_pkg::CFG_DEPTH:   depth_code   <= cfg_data[tgfw_pkg::DEPTH_W-1:0];
          tgfw_pkg::CFG_LASTCOL: last_column  <= cfg_data[tgfw_pkg::COL_W-1:0];
          default: ;
        endcase
      end

      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire && cmd == tgfw_pkg::CMD_CURSOR) begin
            column_now <= cursor_column;
            row_now    <= cursor_row;
          end else if (in_fire && cmd == tgfw_pkg::CMD_PUT) begin
            if (char_code == tgfw_pkg::NEWLINE_CODE) begin
              column_now <= '0;
              row_now    <= row_inc;
            end else if (depth_code > tgfw_pkg::DEPTH_32BPP) begin
              // no pixels, cursor still moves
              column_now <= adv_col;
              row_now    <= adv_row;
            end else begin
              line_idx <= '0;
              word_idx <= '0;
              state    <= ST_MUL;
            end
          end
        end
        ST_MUL: state <= ST_SUM;
        ST_SUM: state <= ST_EMIT;
        ST_EMIT: begin
          if (emit_fire) begin
            if (!last_word) begin
              word_idx <= word_idx + 1'b1;
            end else if (!last_line) begin
              word_idx <= '0;
              line_idx <= line_idx + 1'b1;
            end else begin
              column_now <= adv_col;
              row_now    <= adv_row;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      code_base <= in_code_base;
      row_lines <= tgfw_pkg::ROWLINE_W'(row_now)
                 * tgfw_pkg::ROWLINE_W'(tgfw_pkg::GLYPH_HEIGHT);
    end
    if (state == ST_MUL) begin
      prod <= tgfw_pkg::PROD_W'(row_lines) * tgfw_pkg::PROD_W'(line_stride);
    end
    if (state == ST_SUM) begin
      row_base <= row_sum;
      addr_acc <= row_sum;
    end
    if (emit_fire) begin
      address    <= addr_acc;
      data       <= word_data;
      byte_count <= fmt.byte_count;
      last       <= last_word && last_line;
      if (last_word) begin
        row_base <= next_row_base;
        addr_acc <= next_row_base;
      end else begin
        addr_acc <= addr_acc + tgfw_pkg::ADDR_W'(8);
      end
    end
  end

  `TGFW_ASSERT_NOW(a_font_write_idle, font_req.we, state == ST_IDLE, "font write outside idle")
  `TGFW_ASSERT_NOW(a_word_in_range, state == ST_EMIT, word_idx <= fmt.last_word, "word index past row")
  `TGFW_ASSERT_NEXT(a_final_to_idle, emit_fire && last_word && last_line, state == ST_IDLE && out_valid && last, "final write did not end the character")

endmodule
